// ----- src/zwe_pkg.sv -----
`timescale 1ns / 1ps

package zwe_pkg;

    localparam int MAX_GRID_DEF = 1024;

    localparam int NUM_TERMS = 9;
    localparam int GRID_W    = 11;
    localparam int PIX_W     = 10;
    localparam int RECIP_W   = 25;
    localparam int WEIGHT_W  = 16;
    localparam int TERM_W    = 28;
    localparam int POS_W     = 38;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int WAVE_W    = 32;

    localparam logic [GRID_W-1:0]  GRID_SIZE_RST   = 11'd256;
    localparam logic [RECIP_W-1:0] CENTER_RECIP_RST = 25'd65793;
    localparam logic [3:0]         TERM_COUNT_RST  = 4'd9;
    localparam logic [3:0]         TERM_COUNT_MAX  = 4'd9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIZE    = 3'd0,
        CFG_CENTER_RECIP = 3'd1,
        CFG_TERM_COUNT   = 3'd2,
        CFG_WEIGHTS_LO   = 3'd3,
        CFG_WEIGHTS_HI   = 3'd4,
        CFG_WEIGHT_SPH   = 3'd5
    } t_cfg_idx;

    typedef logic [NUM_TERMS-1:0][WEIGHT_W-1:0] t_weight_vec;
    typedef logic [NUM_TERMS-1:0][TERM_W-1:0]   t_term_vec;

    // Scaled pupil coordinates, Q.24, with the grid bounds check result.
    typedef struct packed {
        logic [POS_W-1:0] u;
        logic [POS_W-1:0] v;
        logic             on_grid;
    } t_coord;

    // All nine Zernike terms in Q.24 and the pupil membership flag.
    typedef struct packed {
        t_term_vec term;
        logic      in_pupil;
    } t_terms;

endpackage

// ----- src/zwe_coord.sv -----
`timescale 1ns / 1ps

module zwe_coord import zwe_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [PIX_W-1:0]   i_row,
    input  logic [PIX_W-1:0]   i_col,
    input  logic [GRID_W-1:0]  i_grid_size,
    input  logic [RECIP_W-1:0] i_center_recip,
    output logic               o_valid,
    input  logic               i_ready,
    output t_coord             o_coord
);

    logic [1:0] r_vld;
    logic [1:0] en;

    logic [GRID_W-1:0]  n_eff;
    logic               on_grid;
    logic signed [12:0] dx_full;
    logic signed [12:0] dy_full;

    logic signed [11:0]      r_dx;
    logic signed [11:0]      r_dy;
    logic                    r1_on_grid;
    logic signed [POS_W-1:0] r_u;
    logic signed [POS_W-1:0] r_v;
    logic                    r2_on_grid;

    assign en[1]   = !r_vld[1] || i_ready;
    assign en[0]   = !r_vld[0] || en[1];
    assign o_ready = en[0];
    assign o_valid = r_vld[1];

    // A grid side above the supported maximum is used as the maximum.
    assign n_eff = (32'(i_grid_size) > 32'(MAX_GRID)) ? GRID_W'(MAX_GRID) : i_grid_size;

    assign on_grid = (n_eff >= GRID_W'(2)) && ({1'b0, i_row} < n_eff)
                     && ({1'b0, i_col} < n_eff);

    // Twice the offset from the grid center, exact in whole pixels.
    assign dx_full = $signed({2'b00, i_col, 1'b0}) - $signed({2'b00, n_eff}) + 13'sd1;
    assign dy_full = $signed({2'b00, i_row, 1'b0}) - $signed({2'b00, n_eff}) + 13'sd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            if (en[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dx       <= dx_full[11:0];
            r_dy       <= dy_full[11:0];
            r1_on_grid <= on_grid;
        end
        if (en[1]) begin
            r_u        <= r_dx * $signed({1'b0, i_center_recip});
            r_v        <= r_dy * $signed({1'b0, i_center_recip});
            r2_on_grid <= r1_on_grid;
        end
    end

    assign o_coord.u       = r_u;
    assign o_coord.v       = r_v;
    assign o_coord.on_grid = r2_on_grid;

endmodule

// ----- src/zwe_terms.sv -----
`timescale 1ns / 1ps

module zwe_terms import zwe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_coord i_coord,
    output logic   o_valid,
    input  logic   i_ready,
    output t_terms o_terms
);

    localparam int NSTG = 5;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    // first stage: box check and the three coordinate products
    logic signed [POS_W-1:0] pos_u;
    logic signed [POS_W-1:0] pos_v;
    logic                    in_box;
    logic signed [51:0]      w_uu;
    logic signed [51:0]      w_vv;
    logic signed [51:0]      w_uv;

    logic signed [25:0] r3_u;
    logic signed [25:0] r3_v;
    logic [48:0]        r3_uu;
    logic [48:0]        r3_vv;
    logic [49:0]        r3_uv;
    logic               r3_in;

    // second stage: squared radius and the astigmatism terms
    logic [49:0]        r2_wide;
    logic signed [49:0] uu_minus_vv;

    logic signed [25:0] r4_u;
    logic signed [25:0] r4_v;
    logic [24:0]        r4_r2;
    logic signed [25:0] r4_t4;
    logic signed [26:0] r4_t5;
    logic               r4_in;

    // third stage: coma factor and defocus
    logic signed [27:0] coma_f;

    logic signed [25:0] r5_u;
    logic signed [25:0] r5_v;
    logic [24:0]        r5_r2;
    logic signed [26:0] r5_c;
    logic signed [26:0] r5_t3;
    logic signed [25:0] r5_t4;
    logic signed [26:0] r5_t5;
    logic               r5_in;

    // fourth stage: coma products and the square of the radius term
    logic signed [28:0] sph_lin;

    logic signed [25:0] r6_u;
    logic signed [25:0] r6_v;
    logic signed [52:0] r6_p6;
    logic signed [52:0] r6_p7;
    logic [49:0]        r6_rr;
    logic signed [27:0] r6_t8a;
    logic signed [26:0] r6_t3;
    logic signed [25:0] r6_t4;
    logic signed [26:0] r6_t5;
    logic               r6_in;

    // last stage: final terms
    logic [25:0]        rr_hi;
    logic [TERM_W-1:0]  rr_six;
    t_term_vec          r7_term;
    logic               r7_in;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign pos_u  = $signed(i_coord.u);
    assign pos_v  = $signed(i_coord.v);
    assign in_box = (pos_u <= 38'sd16777216) && (pos_u >= -38'sd16777216)
                    && (pos_v <= 38'sd16777216) && (pos_v >= -38'sd16777216);
    assign w_uu   = $signed(pos_u[25:0]) * $signed(pos_u[25:0]);
    assign w_vv   = $signed(pos_v[25:0]) * $signed(pos_v[25:0]);
    assign w_uv   = $signed(pos_u[25:0]) * $signed(pos_v[25:0]);

    assign r2_wide     = {1'b0, r3_uu} + {1'b0, r3_vv};
    assign uu_minus_vv = $signed({1'b0, r3_uu}) - $signed({1'b0, r3_vv});

    assign coma_f = $signed({3'b000, r4_r2}) + $signed({2'b00, r4_r2, 1'b0})
                    - 28'sd33554432;

    assign sph_lin = 29'sd16777216
                     - ($signed({2'b00, r5_r2, 2'b00}) + $signed({3'b000, r5_r2, 1'b0}));

    assign rr_hi  = r6_rr[49:24];
    assign rr_six = {rr_hi, 2'b00} + {1'b0, rr_hi, 1'b0};

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r3_u  <= pos_u[25:0];
            r3_v  <= pos_v[25:0];
            r3_uu <= w_uu[48:0];
            r3_vv <= w_vv[48:0];
            r3_uv <= w_uv[49:0];
            r3_in <= i_coord.on_grid && in_box;
        end
        if (en[1]) begin
            r4_u  <= r3_u;
            r4_v  <= r3_v;
            r4_r2 <= r2_wide[48:24];
            r4_t4 <= uu_minus_vv[49:24];
            r4_t5 <= r3_uv[49:23];
            // The disk test uses the exact Q.48 squared radius.
            r4_in <= r3_in && (r2_wide <= 50'h1000000000000);
        end
        if (en[2]) begin
            r5_u  <= r4_u;
            r5_v  <= r4_v;
            r5_r2 <= r4_r2;
            r5_c  <= coma_f[26:0];
            r5_t3 <= $signed({1'b0, r4_r2, 1'b0}) - 27'sd16777216;
            r5_t4 <= r4_t4;
            r5_t5 <= r4_t5;
            r5_in <= r4_in;
        end
        if (en[3]) begin
            r6_u   <= r5_u;
            r6_v   <= r5_v;
            r6_p6  <= r5_u * r5_c;
            r6_p7  <= r5_v * r5_c;
            r6_rr  <= r5_r2 * r5_r2;
            r6_t8a <= sph_lin[27:0];
            r6_t3  <= r5_t3;
            r6_t4  <= r5_t4;
            r6_t5  <= r5_t5;
            r6_in  <= r5_in;
        end
        if (en[4]) begin
            r7_term[0] <= TERM_W'(28'sd16777216);
            r7_term[1] <= {{2{r6_u[25]}}, r6_u};
            r7_term[2] <= {{2{r6_v[25]}}, r6_v};
            r7_term[3] <= {r6_t3[26], r6_t3};
            r7_term[4] <= {{2{r6_t4[25]}}, r6_t4};
            r7_term[5] <= {r6_t5[26], r6_t5};
            r7_term[6] <= r6_p6[51:24];
            r7_term[7] <= r6_p7[51:24];
            r7_term[8] <= r6_t8a + rr_six;
            r7_in      <= r6_in;
        end
    end

    assign o_terms.term     = r7_term;
    assign o_terms.in_pupil = r7_in;

endmodule

// ----- src/zwe_accum.sv -----
`timescale 1ns / 1ps

module zwe_accum import zwe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_terms            i_terms,
    input  t_weight_vec       i_weights,
    input  logic [3:0]        i_term_count,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WAVE_W-1:0] o_wavefront,
    output logic              o_inside
);

    localparam int NSTG   = 4;
    localparam int PROD_W = WEIGHT_W + TERM_W;
    localparam int PART_W = PROD_W + 2;
    localparam int ACC_W  = PROD_W + 4;
    localparam int SH_W   = ACC_W - 13;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    logic [3:0]               terms_used;
    logic signed [PROD_W-1:0] w_prod [NUM_TERMS];
    logic signed [SH_W-1:0]   scaled;
    logic [WAVE_W-1:0]        sat;

    logic signed [PROD_W-1:0] r_prod [NUM_TERMS];
    logic                     r8_in;
    logic signed [PART_W-1:0] r_part [3];
    logic                     r9_in;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r10_in;
    logic [WAVE_W-1:0]        r_wave;
    logic                     r11_in;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign terms_used = (i_term_count > TERM_COUNT_MAX) ? TERM_COUNT_MAX : i_term_count;

    always_comb begin
        for (int k = 0; k < NUM_TERMS; k++) begin
            w_prod[k] = $signed(i_weights[k]) * $signed(i_terms.term[k]);
        end
    end

    // Floor to Q.23 is an arithmetic shift; the sum saturates to 32 bits.
    assign scaled = r_acc[ACC_W-1:13];

    always_comb begin
        if (scaled[SH_W-1:WAVE_W-1] == '0 || scaled[SH_W-1:WAVE_W-1] == '1) begin
            sat = scaled[WAVE_W-1:0];
        end else if (scaled[SH_W-1]) begin
            sat = {1'b1, {(WAVE_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(WAVE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < NUM_TERMS; k++) begin
                r_prod[k] <= (4'(k) < terms_used) ? w_prod[k] : '0;
            end
            r8_in <= i_terms.in_pupil;
        end
        if (en[1]) begin
            for (int j = 0; j < 3; j++) begin
                r_part[j] <= PART_W'(r_prod[3*j]) + PART_W'(r_prod[3*j+1])
                             + PART_W'(r_prod[3*j+2]);
            end
            r9_in <= r8_in;
        end
        if (en[2]) begin
            r_acc  <= ACC_W'(r_part[0]) + ACC_W'(r_part[1]) + ACC_W'(r_part[2]);
            r10_in <= r9_in;
        end
        if (en[3]) begin
            r_wave <= r10_in ? sat : '0;
            r11_in <= r10_in;
        end
    end

    assign o_wavefront = r_wave;
    assign o_inside    = r11_in;

endmodule

// ----- src/zernike_wavefront_eval.sv -----
// Nine-term Zernike wavefront evaluator, one pupil pixel per item.
// An item accepted on s_axis passes through the coordinate, term and accumulation pipelines to m_axis.
// Throughput: one item per cycle while m_axis_tready is high; every stage holds its item under back-pressure.
// Reset clears all stage valid bits and loads the default configuration.
`timescale 1ns / 1ps

module zernike_wavefront_eval import zwe_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // row [9:0], col [19:10], zero pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [WAVE_W-1:0]     m_axis_tdata,  // wavefront [31:0]
    output logic [0:0]            m_axis_tuser,  // inside_pupil [0]
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [GRID_W-1:0]     r_grid_size;
    logic [RECIP_W-1:0]    r_center_recip;
    logic [3:0]            r_term_count;
    logic [CFG_DATA_W-1:0] r_weights_lo;
    logic [CFG_DATA_W-1:0] r_weights_hi;
    logic [WEIGHT_W-1:0]   r_weight_sph;

    t_weight_vec weights;

    logic   coord_valid;
    logic   coord_ready;
    t_coord coord;
    logic   terms_valid;
    logic   terms_ready;
    t_terms terms;
    logic   pupil_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size    <= GRID_SIZE_RST;
            r_center_recip <= CENTER_RECIP_RST;
            r_term_count   <= TERM_COUNT_RST;
            r_weights_lo   <= '0;
            r_weights_hi   <= '0;
            r_weight_sph   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_SIZE: begin
                    r_grid_size <= i_cfg_data[GRID_W-1:0];
                end
                CFG_CENTER_RECIP: begin
                    r_center_recip <= i_cfg_data[RECIP_W-1:0];
                end
                CFG_TERM_COUNT: begin
                    r_term_count <= i_cfg_data[3:0];
                end
                CFG_WEIGHTS_LO: begin
                    r_weights_lo <= i_cfg_data;
                end
                CFG_WEIGHTS_HI: begin
                    r_weights_hi <= i_cfg_data;
                end
                CFG_WEIGHT_SPH: begin
                    r_weight_sph <= i_cfg_data[WEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            weights[k]     = r_weights_lo[WEIGHT_W*k +: WEIGHT_W];
            weights[k + 4] = r_weights_hi[WEIGHT_W*k +: WEIGHT_W];
        end
        weights[NUM_TERMS-1] = r_weight_sph;
    end

    zwe_coord #(
        .MAX_GRID (MAX_GRID)
    ) u_coord (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_row          (s_axis_tdata[9:0]),
        .i_col          (s_axis_tdata[19:10]),
        .i_grid_size    (r_grid_size),
        .i_center_recip (r_center_recip),
        .o_valid        (coord_valid),
        .i_ready        (coord_ready),
        .o_coord        (coord)
    );

    zwe_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (coord_valid),
        .o_ready (coord_ready),
        .i_coord (coord),
        .o_valid (terms_valid),
        .i_ready (terms_ready),
        .o_terms (terms)
    );

    zwe_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (terms_valid),
        .o_ready      (terms_ready),
        .i_terms      (terms),
        .i_weights    (weights),
        .i_term_count (r_term_count),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_wavefront  (m_axis_tdata),
        .o_inside     (pupil_flag)
    );

    assign m_axis_tuser[0] = pupil_flag;

`ifndef NO_ASSERTIONS
    // An empty or draining output stage always lets the front of the pipeline move.
    a_front_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled although the output stage can move");

    // Pixels outside the pupil carry a zero wavefront.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("nonzero wavefront for a pixel outside the pupil");

    // With no terms selected the sum is empty.
    a_no_terms_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_term_count == 4'd0) |-> (m_axis_tdata == '0))
        else $error("nonzero wavefront with no terms selected");

    // A stalled result keeps its pupil flag and value.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata)
            && $stable(m_axis_tuser)))
        else $error("stalled result changed");
`endif

endmodule

// ----- tb/zernike_wavefront_eval_tb.sv -----
`timescale 1ns / 1ps

module zernike_wavefront_eval_tb;
    import zwe_pkg::*;

    // Drain wait, longer than the pipeline of the block.
    localparam int     DRAIN_CYCLES = 24;
    localparam int     STALL_LIMIT  = 4000;
    localparam longint Q24_ONE      = longint'(1) << 24;
    localparam longint Q48_ONE      = longint'(1) << 48;
    localparam longint WAVE_MAX     = 64'sd2147483647;
    localparam longint WAVE_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic [WAVE_W-1:0] wave;
        logic              in_pupil;
    } t_wave_res;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;  // row [9:0], col [19:10], zero pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [WAVE_W-1:0]     m_axis_tdata;        // wavefront [31:0]
    logic [0:0]            m_axis_tuser;        // inside_pupil [0]
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // Shadow copy of the configuration registers.
    logic [GRID_W-1:0]   grid_r  = GRID_SIZE_RST;
    logic [RECIP_W-1:0]  recip_r = CENTER_RECIP_RST;
    logic [3:0]          terms_r = TERM_COUNT_RST;
    logic [63:0]         wlo_r   = '0;
    logic [63:0]         whi_r   = '0;
    logic [WEIGHT_W-1:0] wsph_r  = '0;

    logic [23:0]  pixel_q[$];
    t_wave_res    wave_q[$];
    int unsigned  pixels_queued = 0;
    int unsigned  pixels_taken  = 0;
    int           mismatch_cnt  = 0;
    int           src_idle_pct  = 34;
    int           sink_idle_pct = 34;
    bit           src_hold      = 1'b0;

    zernike_wavefront_eval dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Expected wavefront of one pixel under the shadow configuration.
    function automatic t_wave_res zernike_predict(input logic [PIX_W-1:0] row,
                                                  input logic [PIX_W-1:0] col);
        t_wave_res           r;
        longint              n, rc, u, v, r2w, r2, acc, res;
        longint              t [NUM_TERMS];
        logic [WEIGHT_W-1:0] w;
        int                  nt;
        r = '0;
        n = longint'(grid_r);
        if (n > MAX_GRID_DEF)
            n = MAX_GRID_DEF;
        if (n < 2 || row >= n || col >= n)
            return r;
        rc = longint'(recip_r);
        u = (2 * longint'(col) - (n - 1)) * rc;
        v = (2 * longint'(row) - (n - 1)) * rc;
        if (u > Q24_ONE || u < -Q24_ONE || v > Q24_ONE || v < -Q24_ONE)
            return r;
        r2w = u * u + v * v;
        if (r2w > Q48_ONE)
            return r;
        r2 = r2w >>> 24;
        t[0] = Q24_ONE;
        t[1] = u;
        t[2] = v;
        t[3] = 2 * r2 - Q24_ONE;
        t[4] = (u * u - v * v) >>> 24;
        t[5] = (2 * u * v) >>> 24;
        t[6] = (u * (3 * r2 - 2 * Q24_ONE)) >>> 24;
        t[7] = (v * (3 * r2 - 2 * Q24_ONE)) >>> 24;
        t[8] = Q24_ONE - 6 * r2 + 6 * ((r2 * r2) >>> 24);
        nt = (terms_r > TERM_COUNT_MAX) ? NUM_TERMS : int'(terms_r);
        acc = 0;
        for (int k = 0; k < nt; k++) begin
            w = (k < 4) ? wlo_r[16*k +: 16] : (k < 8) ? whi_r[16*(k-4) +: 16] : wsph_r;
            acc += longint'($signed(w)) * t[k];
        end
        res = acc >>> 13;
        if (res > WAVE_MAX)
            res = WAVE_MAX;
        if (res < WAVE_MIN)
            res = WAVE_MIN;
        r.wave     = res[WAVE_W-1:0];
        r.in_pupil = 1'b1;
        return r;
    endfunction

    function automatic longint fit_recip(input int n);
        int m;
        m = (n > MAX_GRID_DEF) ? MAX_GRID_DEF : n;
        if (m < 2)
            return longint'($urandom_range(1 << 24));
        return ((longint'(1) << 24) + (m - 1) / 2) / (m - 1);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_GRID_SIZE:    grid_r  = val[GRID_W-1:0];
            CFG_CENTER_RECIP: recip_r = val[RECIP_W-1:0];
            CFG_TERM_COUNT:   terms_r = val[3:0];
            CFG_WEIGHTS_LO:   wlo_r   = val;
            CFG_WEIGHTS_HI:   whi_r   = val;
            CFG_WEIGHT_SPH:   wsph_r  = val[WEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    // With junk set, the bits above each register's width carry random garbage.
    task automatic load_config(input int grid, input longint recip, input int terms,
                               input logic [63:0] wlo, input logic [63:0] whi,
                               input logic [15:0] wsph, input bit junk);
        logic [63:0] hi;
        hi = junk ? rand64() : '0;
        write_reg(CFG_GRID_SIZE,    {hi[63:GRID_W], GRID_W'(grid)});
        write_reg(CFG_CENTER_RECIP, {hi[63:RECIP_W], RECIP_W'(recip)});
        write_reg(CFG_TERM_COUNT,   {hi[63:4], 4'(terms)});
        write_reg(CFG_WEIGHTS_LO,   wlo);
        write_reg(CFG_WEIGHTS_HI,   whi);
        write_reg(CFG_WEIGHT_SPH,   {hi[63:16], wsph});
    endtask

    task automatic send_pixel(input int row, input int col);
        pixel_q.push_back({4'b0, PIX_W'(col), PIX_W'(row)});
        pixels_queued++;
    endtask

    task automatic wait_idle();
        while (pixels_taken != pixels_queued || wave_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Pixel driver: the expectation is computed when the item is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                wave_q.push_back(zernike_predict(s_axis_tdata[9:0], s_axis_tdata[19:10]));
                pixels_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_q.size() > 0 && !src_hold && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pixel_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin : result_mon
        t_wave_res want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (wave_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result with none expected: wavefront %h inside %b",
                                 $realtime, m_axis_tdata, m_axis_tuser[0]);
                end else begin
                    want = wave_q.pop_front();
                    if (m_axis_tdata !== want.wave || m_axis_tuser[0] !== want.in_pupil) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: expected wavefront %h inside %b, got %h inside %b",
                                     $realtime, want.wave, want.in_pupil,
                                     m_axis_tdata, m_axis_tuser[0]);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int          grid, terms, n_eff, items;
        longint      recip;
        logic [63:0] wlo, whi;
        logic [15:0] wsph;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: weights are zero, so only inside_pupil varies.
        send_pixel(127, 127);
        send_pixel(0, 0);
        send_pixel(200, 100);
        wait_idle();

        load_config(256, 65793, 9, rand64(), rand64(), 16'($urandom), 1'b0);
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(0, 1023);
        send_pixel(1023, 0);
        send_pixel(256, 0);
        send_pixel(0, 256);
        send_pixel(255, 255);
        send_pixel(127, 127);
        send_pixel(128, 128);
        send_pixel(127, 128);
        send_pixel(0, 127);
        send_pixel(127, 0);
        send_pixel(255, 128);
        send_pixel(64, 64);
        send_pixel(200, 40);
        wait_idle();

        // No terms summed: inside pixels give zero with the flag set.
        load_config(256, 65793, 0, rand64(), rand64(), 16'($urandom), 1'b0);
        send_pixel(127, 127);
        send_pixel(100, 150);
        wait_idle();

        // Grid of one pixel: everything is off the grid.
        load_config(1, 1 << 24, 9, rand64(), rand64(), 16'($urandom), 1'b1);
        send_pixel(0, 0);
        send_pixel(0, 1);
        wait_idle();

        // Oversized grid and term count, with garbage above the register widths.
        load_config(2047, fit_recip(1024), 15, rand64(), rand64(), 16'($urandom), 1'b1);
        send_pixel(511, 511);
        send_pixel(512, 512);
        send_pixel(1023, 1023);
        wait_idle();

        for (int ph = 0; ph < 11; ph++) begin
            case (ph)
                0:       grid = 1024;
                1:       grid = 2;
                2:       grid = $urandom_range(2047, 1025);
                3:       grid = $urandom_range(1);
                default: begin
                    case ($urandom_range(4))
                        0:       grid = $urandom_range(8, 3);
                        1:       grid = 1024;
                        default: grid = $urandom_range(1024, 2);
                    endcase
                end
            endcase
            case ($urandom_range(9))
                0:       recip = 0;
                1:       recip = longint'(1) << 24;
                2:       recip = $urandom_range((1 << 25) - 1);
                3:       recip = $urandom_range(1 << 24);
                default: recip = fit_recip(grid);
            endcase
            case (ph)
                4:       terms = 0;
                5:       terms = 15;
                6:       terms = 9;
                default: terms = $urandom_range(15);
            endcase
            case (ph)
                7: begin
                    wlo  = {4{16'h7FFF}};
                    whi  = {4{16'h7FFF}};
                    wsph = 16'h7FFF;
                end
                8: begin
                    wlo  = {4{16'h8000}};
                    whi  = {4{16'h8000}};
                    wsph = 16'h8000;
                end
                default: begin
                    wlo  = rand64();
                    whi  = rand64();
                    wsph = 16'($urandom);
                end
            endcase
            load_config(grid, recip, terms, wlo, whi, wsph, 1'($urandom_range(1)));

            // One phase runs with both sides at full rate.
            src_idle_pct  = (ph == 9) ? 0 : 34;
            sink_idle_pct = (ph == 9) ? 0 : 34;
            items = (ph == 9) ? 100 : 62;
            n_eff = (grid > MAX_GRID_DEF) ? MAX_GRID_DEF : grid;
            for (int i = 0; i < items; i++) begin
                if (n_eff >= 2 && $urandom_range(9) < 8)
                    send_pixel($urandom_range(n_eff - 1), $urandom_range(n_eff - 1));
                else
                    send_pixel($urandom_range(1023), $urandom_range(1023));
            end

            if (ph == 5) begin
                // Halt the sender midway until the pipeline has fully drained.
                while (pixel_q.size() > items / 2)
                    @(posedge i_clk);
                src_hold = 1'b1;
                @(posedge i_clk);
                while (s_axis_tvalid || wave_q.size() != 0)
                    @(posedge i_clk);
                src_hold = 1'b0;
            end
            wait_idle();
        end

        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
src/zwe_pkg.sv
src/zwe_coord.sv
src/zwe_terms.sv
src/zwe_accum.sv
src/zernike_wavefront_eval.sv
tb/zernike_wavefront_eval_tb.sv
